// ===== src/ball_pair_collision_response_defines.svh =====
// assertion macros shared by the ball pair collision response rtl
// no dependencies; included by the files that carry checks
`ifndef BALL_PAIR_COLLISION_RESPONSE_DEFINES_SVH
`define BALL_PAIR_COLLISION_RESPONSE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// check that sleeps while reset is asserted
`define BPCR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// check that also runs across reset
`define BPCR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BPCR_ASSERT(lbl, clk, rstn, prop, msg)
`define BPCR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== src/bpcr_pkg.sv =====
// shared widths, register codes and beat structs of the collision pipeline
// no dependencies
package bpcr_pkg;

    localparam int WORD_W       = 32;
    localparam int MAG_W        = 31;
    localparam int NUM_W        = 64;
    localparam int LANES        = 4;
    localparam int DIV_STEPS    = NUM_W;
    localparam int FRONT_STAGES = 4;
    localparam int BACK_STAGES  = 5;
    localparam int LATENCY      = FRONT_STAGES + DIV_STEPS + BACK_STAGES;
    localparam int CNT_W        = $clog2(LATENCY + 1);

    localparam int FRAC_W       = 16;
    localparam int RESTI_W      = 17;
    localparam int CAP_W        = 41;
    localparam int PROD_W       = CAP_W + RESTI_W;
    localparam int SCALED_W     = PROD_W - FRAC_W;
    localparam int STEP_W       = 2 * WORD_W - FRAC_W;
    localparam int SUM_W        = STEP_W + 2;

    localparam logic [NUM_W-1:0]  QUOT_CAP       = NUM_W'(64'h100_0000_0000);
    localparam logic [WORD_W-1:0] TIME_STEP_RST  = WORD_W'(1092);
    localparam logic [RESTI_W-1:0] RESTI_RST     = RESTI_W'(65536);
    localparam logic [WORD_W-1:0] WORD_MAX       = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] WORD_MIN       = {1'b1, {(WORD_W-1){1'b0}}};

    // lane order: x of a, y of a, x of b, y of b; partner lane is index xor 2
    localparam int LANE_XA = 0;
    localparam int LANE_YA = 1;
    localparam int LANE_XB = 2;
    localparam int LANE_YB = 3;

    typedef enum logic {
        CFG_TIME_STEP   = 1'b0,
        CFG_RESTITUTION = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [LANES-1:0][WORD_W-1:0] pos;
        logic [LANES-1:0][WORD_W-1:0] vel;
        logic [MAG_W-1:0]             radius_a;
        logic [MAG_W-1:0]             mass_a;
        logic [MAG_W-1:0]             radius_b;
        logic [MAG_W-1:0]             mass_b;
    } in_beat_t;

    typedef struct packed {
        logic                         hit;
        logic [LANES-1:0][WORD_W-1:0] pos;
        logic [LANES-1:0][WORD_W-1:0] vel;
    } side_t;

    typedef struct packed {
        logic              neg;
        logic [WORD_W-1:0] rem;
        logic [NUM_W-1:0]  nq;
    } div_lane_t;

    typedef struct packed {
        logic [WORD_W-1:0]           msum;
        div_lane_t [LANES-1:0]       lane;
        side_t                       side;
    } div_beat_t;

endpackage

// ===== src/ball_pair_collision_response.sv =====
// an accepted input beat runs through the front stages, the quotient chain and the back stages to its result beat
// throughput: one beat per cycle; the whole pipeline advances whenever the
// output register is empty or being taken, the 64-step quotient chain sets the depth
// reset: synchronous active-low aresetn clears all valid bits and the in-flight count,
// time_step returns to 1092 and restitution to 65536; no clearing pass
`include "ball_pair_collision_response_defines.svh"
module ball_pair_collision_response (
    input  logic        aclk,
    input  logic        aresetn,
    // register write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    // input beats
    input  logic        s_valid,
    output logic        s_ready,
    input  logic signed [31:0] s_pos_x_a,
    input  logic signed [31:0] s_pos_y_a,
    input  logic signed [31:0] s_vel_x_a,
    input  logic signed [31:0] s_vel_y_a,
    input  logic [30:0] s_radius_a,
    input  logic [30:0] s_mass_a,
    input  logic signed [31:0] s_pos_x_b,
    input  logic signed [31:0] s_pos_y_b,
    input  logic signed [31:0] s_vel_x_b,
    input  logic signed [31:0] s_vel_y_b,
    input  logic [30:0] s_radius_b,
    input  logic [30:0] s_mass_b,
    // result beats
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_hit,
    output logic signed [31:0] m_new_pos_x_a,
    output logic signed [31:0] m_new_pos_y_a,
    output logic signed [31:0] m_new_vel_x_a,
    output logic signed [31:0] m_new_vel_y_a,
    output logic signed [31:0] m_new_pos_x_b,
    output logic signed [31:0] m_new_pos_y_b,
    output logic signed [31:0] m_new_vel_x_b,
    output logic signed [31:0] m_new_vel_y_b
);
    import bpcr_pkg::*;

    // configuration registers
    logic [WORD_W-1:0]  time_step_reg, time_step_next;
    logic [RESTI_W-1:0] restitution_reg, restitution_next;

    // pipeline advance: every stage moves when the output slot frees up
    logic      en;
    in_beat_t  in_beat;
    side_t     out_beat;
    logic      div_valid [DIV_STEPS+1];
    div_beat_t div_beat  [DIV_STEPS+1];

    // beats in flight, for the checks below
    logic [CNT_W-1:0] inflight_reg, inflight_next;

    always_comb begin
        time_step_next   = time_step_reg;
        restitution_next = restitution_reg;
        if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_TIME_STEP: begin
                    time_step_next = cfg_wdata;
                end
                CFG_RESTITUTION: begin
                    restitution_next = cfg_wdata[RESTI_W-1:0];
                end
                default: begin
                    time_step_next = time_step_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_step_reg   <= TIME_STEP_RST;
            restitution_reg <= RESTI_RST;
        end else begin
            time_step_reg   <= time_step_next;
            restitution_reg <= restitution_next;
        end
    end

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // lane order x of a, y of a, x of b, y of b
    always_comb begin
        in_beat.pos[LANE_XA] = s_pos_x_a;
        in_beat.pos[LANE_YA] = s_pos_y_a;
        in_beat.pos[LANE_XB] = s_pos_x_b;
        in_beat.pos[LANE_YB] = s_pos_y_b;
        in_beat.vel[LANE_XA] = s_vel_x_a;
        in_beat.vel[LANE_YA] = s_vel_y_a;
        in_beat.vel[LANE_XB] = s_vel_x_b;
        in_beat.vel[LANE_YB] = s_vel_y_b;
        in_beat.radius_a     = s_radius_a;
        in_beat.mass_a       = s_mass_a;
        in_beat.radius_b     = s_radius_b;
        in_beat.mass_b       = s_mass_b;
    end

    // overlap test and exchange numerators, four stages
    bpcr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_beat   (in_beat),
        .out_valid (div_valid[0]),
        .out_beat  (div_beat[0])
    );

    // numerator over mass sum, one quotient bit per stage
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        bpcr_div_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (div_valid[k]),
            .in_beat   (div_beat[k]),
            .out_valid (div_valid[k+1]),
            .out_beat  (div_beat[k+1])
        );
    end

    // scale, clamp, advance; the last stage is the output register
    bpcr_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .time_step   (time_step_reg),
        .restitution (restitution_reg),
        .in_valid    (div_valid[DIV_STEPS]),
        .in_beat     (div_beat[DIV_STEPS]),
        .out_valid   (m_valid),
        .out_beat    (out_beat)
    );

    assign m_hit         = out_beat.hit;
    assign m_new_pos_x_a = out_beat.pos[LANE_XA];
    assign m_new_pos_y_a = out_beat.pos[LANE_YA];
    assign m_new_vel_x_a = out_beat.vel[LANE_XA];
    assign m_new_vel_y_a = out_beat.vel[LANE_YA];
    assign m_new_pos_x_b = out_beat.pos[LANE_XB];
    assign m_new_pos_y_b = out_beat.pos[LANE_YB];
    assign m_new_vel_x_b = out_beat.vel[LANE_XB];
    assign m_new_vel_y_b = out_beat.vel[LANE_YB];

    always_comb begin
        inflight_next = inflight_reg + CNT_W'(s_valid && s_ready) - CNT_W'(m_valid && m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    `BPCR_ASSERT(a_result_has_source, aclk, aresetn, m_valid |-> inflight_reg != '0, "result beat with nothing in flight")
    `BPCR_ASSERT(a_inflight_bound, aclk, aresetn, inflight_reg <= CNT_W'(LATENCY), "more beats in flight than pipeline stages")
    `BPCR_ASSERT(a_no_shortcut, aclk, aresetn, (s_valid && s_ready && inflight_reg == '0) |=> !m_valid, "beat reached output without crossing the pipeline")
    `BPCR_ASSERT_ALWAYS(a_reset_empties, aclk, !aresetn |=> !m_valid && inflight_reg == '0, "pipeline not empty after reset")

endmodule

// ===== src/bpcr_front.sv =====
// front stages: distance test, exchange numerators and their magnitudes
// depends on bpcr_pkg
module bpcr_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  bpcr_pkg::in_beat_t   in_beat,
    output logic                 out_valid,
    output bpcr_pkg::div_beat_t  out_beat
);
    import bpcr_pkg::*;

    // stage a: differences and mass terms
    logic                     a_valid_reg;
    logic [WORD_W-1:0]        a_dx_reg, a_dy_reg, a_rs_reg, a_msum_reg;
    logic signed [WORD_W-1:0] a_mdiff_reg [LANES];
    logic [MAG_W-1:0]         a_mother_reg [LANES];
    side_t                    a_side_reg;

    // stage b: products
    logic                     b_valid_reg;
    logic [NUM_W-1:0]         b_sx_reg, b_sy_reg, b_rr_reg;
    logic signed [NUM_W-1:0]  b_t1_reg [LANES];
    logic signed [NUM_W-1:0]  b_t2_reg [LANES];
    logic [WORD_W-1:0]        b_msum_reg;
    side_t                    b_side_reg;

    // stage c: sums and overlap flag
    logic                     c_valid_reg;
    logic [NUM_W:0]           c_s_reg [LANES];
    logic [WORD_W-1:0]        c_msum_reg;
    side_t                    c_side_reg;

    // stage d: magnitudes, registered into the divider beat
    logic                     d_valid_reg;
    div_beat_t                d_beat_reg;

    logic signed [WORD_W:0]   diff_x, diff_y;
    logic [WORD_W-1:0]        dx_next, dy_next, rs_next, msum_next;
    logic signed [WORD_W-1:0] mdiff_ab;
    logic [NUM_W:0]           ssum;
    div_beat_t                d_beat_next;

    always_comb begin
        diff_x = $signed({in_beat.pos[LANE_XA][WORD_W-1], in_beat.pos[LANE_XA]})
               - $signed({in_beat.pos[LANE_XB][WORD_W-1], in_beat.pos[LANE_XB]});
        diff_y = $signed({in_beat.pos[LANE_YA][WORD_W-1], in_beat.pos[LANE_YA]})
               - $signed({in_beat.pos[LANE_YB][WORD_W-1], in_beat.pos[LANE_YB]});
        dx_next   = diff_x[WORD_W] ? WORD_W'(-diff_x) : WORD_W'(diff_x);
        dy_next   = diff_y[WORD_W] ? WORD_W'(-diff_y) : WORD_W'(diff_y);
        rs_next   = {1'b0, in_beat.radius_a} + {1'b0, in_beat.radius_b};
        msum_next = {1'b0, in_beat.mass_a} + {1'b0, in_beat.mass_b};
        mdiff_ab  = $signed({1'b0, in_beat.mass_a}) - $signed({1'b0, in_beat.mass_b});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_dx_reg   <= dx_next;
            a_dy_reg   <= dy_next;
            a_rs_reg   <= rs_next;
            a_msum_reg <= msum_next;
            a_mdiff_reg[LANE_XA]  <= mdiff_ab;
            a_mdiff_reg[LANE_YA]  <= mdiff_ab;
            a_mdiff_reg[LANE_XB]  <= -mdiff_ab;
            a_mdiff_reg[LANE_YB]  <= -mdiff_ab;
            a_mother_reg[LANE_XA] <= in_beat.mass_b;
            a_mother_reg[LANE_YA] <= in_beat.mass_b;
            a_mother_reg[LANE_XB] <= in_beat.mass_a;
            a_mother_reg[LANE_YB] <= in_beat.mass_a;
            a_side_reg.hit <= 1'b0;
            a_side_reg.pos <= in_beat.pos;
            a_side_reg.vel <= in_beat.vel;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_sx_reg   <= a_dx_reg * a_dx_reg;
            b_sy_reg   <= a_dy_reg * a_dy_reg;
            b_rr_reg   <= a_rs_reg * a_rs_reg;
            b_msum_reg <= a_msum_reg;
            b_side_reg <= a_side_reg;
            for (int i = 0; i < LANES; i++) begin
                // self velocity times mass difference, other mass times other velocity
                b_t1_reg[i] <= $signed(a_side_reg.vel[i]) * a_mdiff_reg[i];
                b_t2_reg[i] <= $signed({1'b0, a_mother_reg[i]})
                             * $signed(a_side_reg.vel[i ^ 2]);
            end
        end
    end

    always_comb begin
        ssum = {1'b0, b_sx_reg} + {1'b0, b_sy_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (en) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_msum_reg     <= b_msum_reg;
            c_side_reg.pos <= b_side_reg.pos;
            c_side_reg.vel <= b_side_reg.vel;
            // a carry out of the square sum is never below the radius square
            c_side_reg.hit <= ssum < {1'b0, b_rr_reg};
            for (int i = 0; i < LANES; i++) begin
                c_s_reg[i] <= {b_t1_reg[i][NUM_W-1], b_t1_reg[i]}
                            + {b_t2_reg[i][NUM_W-1], b_t2_reg[i][NUM_W-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        d_beat_next.msum = c_msum_reg;
        d_beat_next.side = c_side_reg;
        for (int i = 0; i < LANES; i++) begin
            d_beat_next.lane[i].neg = c_s_reg[i][NUM_W];
            d_beat_next.lane[i].rem = '0;
            d_beat_next.lane[i].nq  = c_s_reg[i][NUM_W] ? NUM_W'(~c_s_reg[i] + 1'b1)
                                                         : c_s_reg[i][NUM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (en) begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_beat_reg <= d_beat_next;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_beat  = d_beat_reg;

endmodule

// ===== src/bpcr_div_step.sv =====
// one restoring division step for all four lanes, registered
// depends on bpcr_pkg
module bpcr_div_step (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  bpcr_pkg::div_beat_t  in_beat,
    output logic                 out_valid,
    output bpcr_pkg::div_beat_t  out_beat
);
    import bpcr_pkg::*;

    logic      valid_reg;
    div_beat_t beat_reg;
    div_beat_t beat_next;
    logic [WORD_W:0] r_ext [LANES];
    logic [WORD_W:0] r_sub [LANES];
    logic            ge [LANES];

    always_comb begin
        beat_next = in_beat;
        for (int i = 0; i < LANES; i++) begin
            // bring down the next numerator bit, try the subtract
            r_ext[i] = {in_beat.lane[i].rem, in_beat.lane[i].nq[NUM_W-1]};
            r_sub[i] = r_ext[i] - {1'b0, in_beat.msum};
            ge[i]    = r_ext[i] >= {1'b0, in_beat.msum};
            beat_next.lane[i].rem = ge[i] ? r_sub[i][WORD_W-1:0] : r_ext[i][WORD_W-1:0];
            beat_next.lane[i].nq  = {in_beat.lane[i].nq[NUM_W-2:0], ge[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            beat_reg <= beat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

// ===== src/bpcr_back.sv =====
// back stages: quotient cap, restitution scale, velocity clamp, advance
// depends on bpcr_pkg
module bpcr_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic [bpcr_pkg::WORD_W-1:0]  time_step,
    input  logic [bpcr_pkg::RESTI_W-1:0] restitution,
    input  logic                   in_valid,
    input  bpcr_pkg::div_beat_t    in_beat,
    output logic                   out_valid,
    output bpcr_pkg::side_t        out_beat
);
    import bpcr_pkg::*;

    logic               e_valid_reg, f_valid_reg, g_valid_reg, h_valid_reg, o_valid_reg;
    side_t              e_side_reg, f_side_reg, g_side_reg, h_side_reg, o_side_reg;
    logic [CAP_W-1:0]   e_qc_reg [LANES];
    logic               e_neg_reg [LANES];
    logic [SCALED_W-1:0] f_sc_reg [LANES];
    logic               f_neg_reg [LANES];
    logic [WORD_W-1:0]  g_nv_reg [LANES];
    logic [WORD_W-1:0]  g_mag_reg [LANES];
    logic               g_neg_reg [LANES];
    logic [STEP_W-1:0]  h_p_reg [LANES];
    logic [WORD_W-1:0]  h_nv_reg [LANES];
    logic               h_neg_reg [LANES];

    logic [NUM_W-1:0]   q [LANES];
    logic [PROD_W-1:0]  prod [LANES];
    logic               vneg [LANES];
    logic               big [LANES];
    logic [2*WORD_W-1:0] step_prod [LANES];
    logic [SUM_W-1:0]   psum [LANES];
    logic [WORD_W-1:0]  psat [LANES];
    side_t              o_side_next;

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else if (en) begin
            e_valid_reg <= in_valid;
            f_valid_reg <= e_valid_reg;
            g_valid_reg <= f_valid_reg;
            h_valid_reg <= g_valid_reg;
            o_valid_reg <= h_valid_reg;
        end
    end

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            // a zero mass sum gives a zero quotient
            q[i]    = (in_beat.msum == '0) ? '0 : in_beat.lane[i].nq;
            prod[i] = e_qc_reg[i] * restitution;
            vneg[i] = f_neg_reg[i] && (f_sc_reg[i] != '0);
            big[i]  = vneg[i] ? (f_sc_reg[i] >= SCALED_W'({1'b0, WORD_MIN}))
                              : (f_sc_reg[i] >  SCALED_W'(WORD_MAX));
            step_prod[i] = time_step * g_mag_reg[i];
            psum[i] = h_neg_reg[i]
                    ? {{(SUM_W-WORD_W){h_side_reg.pos[i][WORD_W-1]}}, h_side_reg.pos[i]}
                      - {2'b00, h_p_reg[i]}
                    : {{(SUM_W-WORD_W){h_side_reg.pos[i][WORD_W-1]}}, h_side_reg.pos[i]}
                      + {2'b00, h_p_reg[i]};
            // clamp: upper bits must all match the sign to fit
            if (psum[i][SUM_W-1:WORD_W-1] == '0 || psum[i][SUM_W-1:WORD_W-1] == '1) begin
                psat[i] = psum[i][WORD_W-1:0];
            end else begin
                psat[i] = psum[i][SUM_W-1] ? WORD_MIN : WORD_MAX;
            end
        end
        o_side_next = h_side_reg;
        if (h_side_reg.hit) begin
            for (int i = 0; i < LANES; i++) begin
                o_side_next.pos[i] = psat[i];
                o_side_next.vel[i] = h_nv_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_side_reg <= in_beat.side;
            f_side_reg <= e_side_reg;
            g_side_reg <= f_side_reg;
            h_side_reg <= g_side_reg;
            o_side_reg <= o_side_next;
            for (int i = 0; i < LANES; i++) begin
                e_qc_reg[i]  <= (q[i] > QUOT_CAP) ? QUOT_CAP[CAP_W-1:0] : q[i][CAP_W-1:0];
                e_neg_reg[i] <= in_beat.lane[i].neg;
                f_sc_reg[i]  <= prod[i][PROD_W-1:FRAC_W];
                f_neg_reg[i] <= e_neg_reg[i];
                g_neg_reg[i] <= vneg[i];
                if (vneg[i]) begin
                    g_mag_reg[i] <= big[i] ? WORD_MIN : f_sc_reg[i][WORD_W-1:0];
                    g_nv_reg[i]  <= big[i] ? WORD_MIN : WORD_W'(-f_sc_reg[i]);
                end else begin
                    g_mag_reg[i] <= big[i] ? WORD_MAX : f_sc_reg[i][WORD_W-1:0];
                    g_nv_reg[i]  <= big[i] ? WORD_MAX : f_sc_reg[i][WORD_W-1:0];
                end
                h_p_reg[i]   <= step_prod[i][2*WORD_W-1:FRAC_W];
                h_nv_reg[i]  <= g_nv_reg[i];
                h_neg_reg[i] <= g_neg_reg[i];
            end
        end
    end

    assign out_valid = o_valid_reg;
    assign out_beat  = o_side_reg;

endmodule
